// ===== design/bpva_pkg.sv =====
// ----------------------------------------------------------------------------
// bpva_pkg: shared types and constants
// Opcodes, mapping-chain word layout and address helpers for the buffer
// placement and mapping table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bpva_pkg;

    localparam int ADDR_W       = 48;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    localparam int MAX_BUF_BYTES = 33554432;
    localparam int BYTES_W      = 26;
    localparam int SLOT_FIELD_W = 5;
    localparam int CNT_W        = 11;

    localparam logic [1:0] CFG_AP_BASE  = 2'd0;
    localparam logic [1:0] CFG_AP_BYTES = 2'd1;
    localparam logic [1:0] CFG_VA_BASE  = 2'd2;
    localparam logic [1:0] CFG_VA_BYTES = 2'd3;

    typedef enum logic [3:0] {
        OP_CREATE     = 4'd0,
        OP_RESERVE    = 4'd1,
        OP_UNRESERVE  = 4'd2,
        OP_PLACE_AP   = 4'd3,
        OP_PLACE_SYS  = 4'd4,
        OP_PIN        = 4'd5,
        OP_UNPIN      = 4'd6,
        OP_MAP        = 4'd7,
        OP_UNMAP      = 4'd8,
        OP_DESTROY    = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        MK_CHECK   = 2'd0,
        MK_INSERT  = 2'd1,
        MK_UNMAP   = 2'd2,
        MK_DESTROY = 2'd3
    } map_kind_t;

    // word that travels down the mapping chain, one cell per cycle
    typedef struct packed {
        logic                    valid;
        map_kind_t               kind;
        logic [SLOT_FIELD_W-1:0] owner;
        logic [ADDR_W-1:0]       va;
        logic [BYTES_W-1:0]      len;
        logic                    flag;
        logic [CNT_W-1:0]        cnt;
    } map_word_t;

    // carry-extended sum; the top bit set means the range wraps the address space
    function automatic logic [ADDR_W:0] add_ext(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
        add_ext = {1'b0, a} + {1'b0, b};
    endfunction

endpackage

// ===== design/bpva_cell.sv =====
// ----------------------------------------------------------------------------
// bpva_cell: one mapping entry
// Holds one mapping and updates the passing chain word: overlap check,
// first-free insert, first-match unmap, or owner-wide clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpva_cell
    import bpva_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  map_word_t word_in,
    output map_word_t word_out
);

    logic                    active_reg;
    logic [SLOT_FIELD_W-1:0] owner_reg;
    logic [ADDR_W-1:0]       va_reg;
    logic [BYTES_W-1:0]      len_reg;
    map_word_t               word_reg;

    map_word_t         word_next;
    logic              wr_en;
    logic              clr_en;
    logic [ADDR_W:0]   req_end;
    logic [ADDR_W:0]   own_end;
    logic              overlaps;

    always_comb
    begin
        req_end   = add_ext(word_in.va, ADDR_W'(word_in.len));
        own_end   = add_ext(va_reg, ADDR_W'(len_reg));
        overlaps  = ({1'b0, word_in.va} < own_end) && ({1'b0, va_reg} < req_end);
        word_next = word_in;
        wr_en     = 1'b0;
        clr_en    = 1'b0;
        if (word_in.valid)
        begin
            case (word_in.kind)
                MK_CHECK:
                begin
                    if (active_reg && overlaps)
                        word_next.flag = 1'b1;
                end
                MK_INSERT:
                begin
                    if (!active_reg && !word_in.flag)
                    begin
                        word_next.flag = 1'b1;
                        wr_en          = 1'b1;
                    end
                end
                MK_UNMAP:
                begin
                    if (active_reg && !word_in.flag && owner_reg == word_in.owner &&
                        va_reg == word_in.va)
                    begin
                        word_next.flag = 1'b1;
                        clr_en         = 1'b1;
                    end
                end
                default:
                begin
                    if (active_reg && owner_reg == word_in.owner)
                    begin
                        word_next.cnt = word_in.cnt + CNT_W'(1);
                        clr_en        = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            word_reg   <= '0;
        end
        else
        begin
            word_reg <= word_next;
            if (wr_en)
                active_reg <= 1'b1;
            else if (clr_en)
                active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_reg <= word_in.owner;
            va_reg    <= word_in.va;
            len_reg   <= word_in.len;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== design/bpva_map_chain.sv =====
// ----------------------------------------------------------------------------
// bpva_map_chain: row of mapping cells
// A word enters the first cell and passes through each cell's register in turn before it leaves the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpva_map_chain
    import bpva_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  map_word_t word_in,
    output map_word_t word_out
);

    map_word_t link [DEPTH+1];

    assign link[0] = word_in;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        bpva_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (link[g]),
            .word_out (link[g+1])
        );
    end

    assign word_out = link[DEPTH];

endmodule

// ===== design/buffer_placement_and_va_map_table_unit.sv =====
// ----------------------------------------------------------------------------
// buffer_placement_and_va_map_table_unit: buffer slot and mapping table
// Slot table edits finish in the execute step; aperture placement adds a
// first-fit scan over the buffer slots for each candidate; unmap, destroy and
// an overlapping map make one pass down the mapping chain, an inserted map
// two. One request at a time; busy drops in the cycle done pulses, so the next
// word can be taken at the edge that ends it. The receiver cannot stall.
// Reset clears all slot/mapping valid bits and live counts; presets the config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module buffer_placement_and_va_map_table_unit
    import bpva_pkg::*;
#(
    parameter int BUFFER_SLOTS  = 32,
    parameter int MAPPING_SLOTS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [ADDR_W-1:0]       cfg_data,
    input  logic [3:0]              opcode,
    input  logic [SLOT_FIELD_W-1:0] slot,
    input  logic [27:0]             byte_count,
    input  logic [ADDR_W-1:0]       virt_addr,
    input  logic [24:0]             buffer_offset,
    output logic                    ok,
    output logic [SLOT_FIELD_W-1:0] result_slot,
    output logic [31:0]             handle,
    output logic [ADDR_W-1:0]       placed_addr,
    output logic [BYTES_W-1:0]      buffer_bytes,
    output logic                    in_aperture,
    output logic [5:0]              buffers_live,
    output logic [6:0]              mappings_live
);

    localparam int SLOT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_FIT   = 5'b00100,
        ST_CHAIN = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg;

    // configuration
    logic [ADDR_W-1:0] ap_base_reg;
    logic [40:0]       ap_bytes_reg;
    logic [ADDR_W-1:0] va_base_reg;
    logic [40:0]       va_bytes_reg;

    // latched request word
    logic [3:0]              op_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [27:0]             cnt_reg;
    logic [ADDR_W-1:0]       va_reg;
    logic [24:0]             off_reg;

    // slot table
    logic                slot_active_reg   [BUFFER_SLOTS];
    logic                slot_reserved_reg [BUFFER_SLOTS];
    logic                slot_placed_reg   [BUFFER_SLOTS];
    logic [31:0]         slot_handle_reg   [BUFFER_SLOTS];
    logic [31:0]         slot_pins_reg     [BUFFER_SLOTS];
    logic [BYTES_W-1:0]  slot_bytes_reg    [BUFFER_SLOTS];
    logic [ADDR_W-1:0]   slot_addr_reg     [BUFFER_SLOTS];

    logic [31:0]             next_handle_reg;
    logic [5:0]              live_b_reg;
    logic [6:0]              live_m_reg;
    logic                    ok_reg;
    logic                    valid_reg;
    logic [SLOT_FIELD_W-1:0] rs_reg;
    logic [ADDR_W-1:0]       cand_reg;
    logic [SLOT_W-1:0]       idx_reg;
    map_word_t               launch_reg;
    logic                    done_reg;

    logic                    ok_out_reg;
    logic [SLOT_FIELD_W-1:0] rslot_out_reg;
    logic [31:0]             handle_out_reg;
    logic [ADDR_W-1:0]       addr_out_reg;
    logic [BYTES_W-1:0]      bytes_out_reg;
    logic                    ap_out_reg;

    map_word_t chain_out;

    // decode helpers
    logic [SLOT_W-1:0]  t;
    logic               slot_in_range;
    logic               act, res, plc;
    logic [31:0]        pins;
    logic [BYTES_W-1:0] bytes;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               create_go;
    logic [BYTES_W-1:0] rounded;
    logic [28:0]        round_sum;
    logic [ADDR_W:0]    va_end, va_lim;
    logic [26:0]        off_end;
    logic               map_go;
    logic [ADDR_W:0]    cand_end, ap_lim, i_end;
    logic               cand_fits, i_hit;
    logic [SLOT_W-1:0]  rs_t;
    logic               rs_live;
    map_word_t          word_new;

    // mapping table as a row of cells
    bpva_map_chain #(.DEPTH(MAPPING_SLOTS)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_in  (launch_reg),
        .word_out (chain_out)
    );

    always_comb
    begin
        t             = slot_reg[SLOT_W-1:0];
        slot_in_range = 32'(slot_reg) < BUFFER_SLOTS;
        act   = slot_active_reg[t];
        res   = slot_reserved_reg[t];
        plc   = slot_placed_reg[t];
        pins  = slot_pins_reg[t];
        bytes = slot_bytes_reg[t];

        // lowest free slot for create
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BUFFER_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
        round_sum = 29'(cnt_reg) + 29'(PAGE_BYTES - 1);
        rounded   = BYTES_W'(round_sum & ~29'(PAGE_BYTES - 1));
        create_go = (cnt_reg != '0) && (32'(cnt_reg) <= MAX_BUF_BYTES) && free_found;

        // map request checks: alignment, window, buffer extent
        va_end  = add_ext(va_reg, ADDR_W'(cnt_reg));
        va_lim  = add_ext(va_base_reg, ADDR_W'(va_bytes_reg));
        off_end = 27'(off_reg) + 27'(cnt_reg[25:0]);
        map_go  = act && res && plc &&
                  (va_reg[PAGE_SHIFT-1:0] == '0) && (off_reg[PAGE_SHIFT-1:0] == '0) &&
                  (cnt_reg[PAGE_SHIFT-1:0] == '0) && (cnt_reg != '0) &&
                  !va_end[ADDR_W] && !va_lim[ADDR_W] && (va_reg >= va_base_reg) &&
                  (va_end <= va_lim) && (cnt_reg[27:26] == '0) &&
                  (off_end <= 27'(bytes));

        // first-fit step against slot idx_reg
        cand_end  = add_ext(cand_reg, ADDR_W'(bytes));
        ap_lim    = add_ext(ap_base_reg, ADDR_W'(ap_bytes_reg));
        cand_fits = (bytes != '0) && !cand_end[ADDR_W] && !ap_lim[ADDR_W] &&
                    (cand_reg >= ap_base_reg) && (cand_end <= ap_lim);
        i_end     = add_ext(slot_addr_reg[idx_reg], ADDR_W'(slot_bytes_reg[idx_reg]));
        i_hit     = slot_active_reg[idx_reg] && slot_placed_reg[idx_reg] && (idx_reg != t) &&
                    (cand_end[ADDR_W] || i_end[ADDR_W] ||
                     (({1'b0, cand_reg} < i_end) &&
                      ({1'b0, slot_addr_reg[idx_reg]} < cand_end)));

        rs_t    = rs_reg[SLOT_W-1:0];
        rs_live = valid_reg && slot_active_reg[rs_t];

        word_new       = '0;
        word_new.valid = 1'b1;
        word_new.owner = slot_reg;
        word_new.va    = va_reg;
        word_new.len   = cnt_reg[BYTES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ap_base_reg     <= 48'h0001_0000_0000;
            ap_bytes_reg    <= 41'h000_1000_0000;
            va_base_reg     <= 48'h0010_0000_0000;
            va_bytes_reg    <= 41'h100_0000_0000;
            next_handle_reg <= 32'd1;
            live_b_reg      <= '0;
            live_m_reg      <= '0;
            launch_reg      <= '0;
            done_reg        <= 1'b0;
            for (int i = 0; i < BUFFER_SLOTS; i++)
            begin
                slot_active_reg[i]   <= 1'b0;
                slot_reserved_reg[i] <= 1'b0;
                slot_placed_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            done_reg         <= 1'b0;
            launch_reg.valid <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AP_BASE:  ap_base_reg  <= cfg_data;
                    CFG_AP_BYTES: ap_bytes_reg <= cfg_data[40:0];
                    CFG_VA_BASE:  va_base_reg  <= cfg_data;
                    CFG_VA_BYTES: va_bytes_reg <= cfg_data[40:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    // latch the request word
                    if (start)
                    begin
                        op_reg    <= opcode;
                        slot_reg  <= slot;
                        cnt_reg   <= byte_count;
                        va_reg    <= virt_addr;
                        off_reg   <= buffer_offset;
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    ok_reg    <= 1'b0;
                    rs_reg    <= slot_reg;
                    valid_reg <= slot_in_range;
                    state_reg <= ST_RESP;
                    if (op_reg == OP_CREATE)
                    begin
                        valid_reg <= create_go;
                        rs_reg    <= '0;
                        if (create_go)
                        begin
                            rs_reg <= SLOT_FIELD_W'(free_idx);
                            ok_reg <= 1'b1;
                            slot_active_reg[free_idx]   <= 1'b1;
                            slot_reserved_reg[free_idx] <= 1'b0;
                            slot_placed_reg[free_idx]   <= 1'b0;
                            slot_pins_reg[free_idx]     <= '0;
                            slot_bytes_reg[free_idx]    <= rounded;
                            // skip handle zero on wrap
                            if (next_handle_reg == '0)
                            begin
                                slot_handle_reg[free_idx] <= 32'd1;
                                next_handle_reg           <= 32'd2;
                            end
                            else
                            begin
                                slot_handle_reg[free_idx] <= next_handle_reg;
                                next_handle_reg           <= next_handle_reg + 32'd1;
                            end
                            live_b_reg <= live_b_reg + 6'd1;
                        end
                    end
                    else if (slot_in_range)
                    begin
                        case (op_reg)
                            OP_RESERVE:
                            begin
                                if (act && !res)
                                begin
                                    slot_reserved_reg[t] <= 1'b1;
                                    ok_reg <= 1'b1;
                                end
                            end
                            OP_UNRESERVE:
                            begin
                                if (act)
                                begin
                                    slot_reserved_reg[t] <= 1'b0;
                                    ok_reg <= 1'b1;
                                end
                            end
                            OP_PLACE_AP:
                            begin
                                if (act && res)
                                begin
                                    if (plc)
                                        ok_reg <= 1'b1;
                                    else
                                    begin
                                        cand_reg  <= ap_base_reg;
                                        idx_reg   <= '0;
                                        state_reg <= ST_FIT;
                                    end
                                end
                            end
                            OP_PLACE_SYS:
                            begin
                                if (act && res && (!plc || pins == '0))
                                begin
                                    slot_placed_reg[t] <= 1'b0;
                                    ok_reg <= 1'b1;
                                end
                            end
                            OP_PIN:
                            begin
                                if (act && res && plc && pins != '1)
                                begin
                                    slot_pins_reg[t] <= pins + 32'd1;
                                    ok_reg <= 1'b1;
                                end
                            end
                            OP_UNPIN:
                            begin
                                if (act && res && pins != '0)
                                begin
                                    slot_pins_reg[t] <= pins - 32'd1;
                                    ok_reg <= 1'b1;
                                end
                            end
                            OP_MAP:
                            begin
                                if (map_go)
                                begin
                                    launch_reg      <= word_new;
                                    launch_reg.kind <= MK_CHECK;
                                    state_reg       <= ST_CHAIN;
                                end
                            end
                            OP_UNMAP:
                            begin
                                if (act && res)
                                begin
                                    launch_reg      <= word_new;
                                    launch_reg.kind <= MK_UNMAP;
                                    state_reg       <= ST_CHAIN;
                                end
                            end
                            OP_DESTROY:
                            begin
                                if (act)
                                begin
                                    launch_reg      <= word_new;
                                    launch_reg.kind <= MK_DESTROY;
                                    state_reg       <= ST_CHAIN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_FIT:
                begin
                    // restart of a scan re-checks that the candidate fits the window
                    if (idx_reg == '0 && !cand_fits)
                        state_reg <= ST_RESP;
                    else if (i_hit)
                    begin
                        if (i_end[ADDR_W])
                            state_reg <= ST_RESP;
                        else
                        begin
                            cand_reg <= i_end[ADDR_W-1:0];
                            idx_reg  <= '0;
                        end
                    end
                    else if (32'(idx_reg) == BUFFER_SLOTS - 1)
                    begin
                        slot_placed_reg[t] <= 1'b1;
                        slot_addr_reg[t]   <= cand_reg;
                        ok_reg             <= 1'b1;
                        state_reg          <= ST_RESP;
                    end
                    else
                        idx_reg <= idx_reg + SLOT_W'(1);
                end

                ST_CHAIN:
                begin
                    if (chain_out.valid)
                    begin
                        state_reg <= ST_RESP;
                        case (chain_out.kind)
                            MK_CHECK:
                            begin
                                // no overlap: send the insert pass
                                if (!chain_out.flag)
                                begin
                                    launch_reg      <= word_new;
                                    launch_reg.kind <= MK_INSERT;
                                    state_reg       <= ST_CHAIN;
                                end
                            end
                            MK_INSERT:
                            begin
                                ok_reg <= chain_out.flag;
                                if (chain_out.flag)
                                    live_m_reg <= live_m_reg + 7'd1;
                            end
                            MK_UNMAP:
                            begin
                                ok_reg <= chain_out.flag;
                                if (chain_out.flag)
                                    live_m_reg <= live_m_reg - 7'd1;
                            end
                            default:
                            begin
                                live_m_reg <= live_m_reg - 7'(chain_out.cnt);
                                slot_active_reg[t]   <= 1'b0;
                                slot_reserved_reg[t] <= 1'b0;
                                slot_placed_reg[t]   <= 1'b0;
                                live_b_reg <= live_b_reg - 6'd1;
                                ok_reg     <= 1'b1;
                            end
                        endcase
                    end
                end

                ST_RESP:
                begin
                    // report the addressed slot as it stands now
                    ok_out_reg     <= ok_reg;
                    rslot_out_reg  <= rs_reg;
                    handle_out_reg <= rs_live ? slot_handle_reg[rs_t] : '0;
                    addr_out_reg   <= (rs_live && slot_placed_reg[rs_t]) ?
                                      slot_addr_reg[rs_t] : '1;
                    bytes_out_reg  <= rs_live ? slot_bytes_reg[rs_t] : '0;
                    ap_out_reg     <= rs_live && slot_placed_reg[rs_t];
                    done_reg       <= 1'b1;
                    state_reg      <= ST_IDLE;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign ok            = ok_out_reg;
    assign result_slot   = rslot_out_reg;
    assign handle        = handle_out_reg;
    assign placed_addr   = addr_out_reg;
    assign buffer_bytes  = bytes_out_reg;
    assign in_aperture   = ap_out_reg;
    assign buffers_live  = live_b_reg;
    assign mappings_live = live_m_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_done_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RESP))
        else $error("done without a response step");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(live_b_reg) <= BUFFER_SLOTS) && (32'(live_m_reg) <= MAPPING_SLOTS))
        else $error("live counter beyond table size");
`endif

endmodule

// ===== tb/buffer_placement_and_va_map_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// buffer_placement_and_va_map_table_unit_tb: self-checking bench
// Drives request words through the start/busy handshake, predicts every
// reply from a behavioral copy of the slot and mapping tables, and checks
// each done strobe field by field, across several aperture/window settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module buffer_placement_and_va_map_table_unit_tb;
    import bpva_pkg::*;

    typedef bit [63:0] u64_t;

    localparam int   NBUF      = 32;
    localparam int   NMAP      = 64;
    localparam u64_t AMASK     = (64'd1 << 48) - 1;
    localparam u64_t PG        = 64'd4096;
    localparam int   IDLE_LIMIT = 50000;

    // one expected reply word
    typedef struct {
        bit          ok;
        bit [4:0]    rslot;
        bit [31:0]   hnd;
        bit [47:0]   addr;
        bit [25:0]   nbytes;
        bit          inap;
        bit [5:0]    blive;
        bit [6:0]    mlive;
    } reply_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    done;
    logic                    cfg_we;
    logic [1:0]              cfg_index;
    logic [ADDR_W-1:0]       cfg_data;
    logic [3:0]              opcode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [27:0]             byte_count;
    logic [ADDR_W-1:0]       virt_addr;
    logic [24:0]             buffer_offset;
    logic                    ok;
    logic [SLOT_FIELD_W-1:0] result_slot;
    logic [31:0]             handle;
    logic [ADDR_W-1:0]       placed_addr;
    logic [BYTES_W-1:0]      buffer_bytes;
    logic                    in_aperture;
    logic [5:0]              buffers_live;
    logic [6:0]              mappings_live;

    buffer_placement_and_va_map_table_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .opcode(opcode), .slot(slot), .byte_count(byte_count),
        .virt_addr(virt_addr), .buffer_offset(buffer_offset),
        .ok(ok), .result_slot(result_slot), .handle(handle),
        .placed_addr(placed_addr), .buffer_bytes(buffer_bytes),
        .in_aperture(in_aperture), .buffers_live(buffers_live),
        .mappings_live(mappings_live)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the tables and the registers
    // ------------------------------------------------------------------
    u64_t      ap_base, ap_len, win_base, win_len;
    bit        b_act  [NBUF];
    bit        b_res  [NBUF];
    bit        b_plc  [NBUF];
    bit [31:0] b_hnd  [NBUF];
    bit [31:0] b_pins [NBUF];
    u64_t      b_len  [NBUF];
    u64_t      b_addr [NBUF];
    bit        m_act  [NMAP];
    bit [4:0]  m_own  [NMAP];
    u64_t      m_va   [NMAP];
    u64_t      m_len  [NMAP];
    bit [31:0] handle_ctr;
    int        n_buf, n_map;

    reply_t    reply_q[$];
    int        errors;
    int        replies_seen;
    int        words_sent;
    int        maps_ok, places_ok;
    int        idle_cycles;
    bit        accept_seen;
    bit        no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit add_fits(u64_t a, u64_t b, output u64_t r);
        r = a + b;
        return !(a > AMASK || b > AMASK - a);
    endfunction

    function automatic bit range_within(u64_t st, u64_t sz, u64_t base, u64_t ext);
        u64_t e, l;
        bit   f1, f2;
        f1 = add_fits(st, sz, e);
        f2 = add_fits(base, ext, l);
        return sz != 0 && f1 && f2 && st >= base && e <= l;
    endfunction

    function automatic bit ranges_clash(u64_t as, u64_t an, u64_t bs, u64_t bn);
        u64_t ae, be;
        if (!add_fits(as, an, ae) || !add_fits(bs, bn, be))
            return 1'b1;
        return as < be && bs < ae;
    endfunction

    function automatic void free_buffer(int s);
        b_act[s] = 0; b_res[s] = 0; b_plc[s] = 0; b_hnd[s] = 0;
        b_pins[s] = 0; b_len[s] = 0; b_addr[s] = AMASK;
    endfunction

    function automatic void reset_tables();
        ap_base = 64'h1_0000_0000; ap_len = 64'd256 << 20;
        win_base = 64'h10_0000_0000; win_len = 64'd1 << 40;
        for (int i = 0; i < NBUF; i++) free_buffer(i);
        for (int i = 0; i < NMAP; i++) m_act[i] = 0;
        handle_ctr = 1; n_buf = 0; n_map = 0;
    endfunction

    // first-fit walk through the aperture, bumping past placed neighbors
    function automatic bit aperture_fit(int t, output u64_t where);
        u64_t cand;
        bit   bumped;
        cand = ap_base;
        where = 0;
        while (range_within(cand, b_len[t], ap_base, ap_len)) begin
            bumped = 0;
            for (int i = 0; i < NBUF; i++) begin
                if (!b_act[i] || i == t || !b_plc[i]) continue;
                if (ranges_clash(cand, b_len[t], b_addr[i], b_len[i])) begin
                    if (!add_fits(b_addr[i], b_len[i], cand)) return 0;
                    bumped = 1;
                    break;
                end
            end
            if (!bumped) begin
                where = cand;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit map_insert(int s, u64_t va, u64_t off, u64_t len);
        if (!b_act[s] || !b_res[s] || !b_plc[s] || (va % PG) != 0 || (off % PG) != 0 ||
            (len % PG) != 0 || !range_within(va, len, win_base, win_len) ||
            !range_within(off, len, 0, b_len[s]))
            return 0;
        for (int i = 0; i < NMAP; i++)
            if (m_act[i] && ranges_clash(va, len, m_va[i], m_len[i])) return 0;
        for (int i = 0; i < NMAP; i++)
            if (!m_act[i]) begin
                m_act[i] = 1; m_own[i] = 5'(s); m_va[i] = va; m_len[i] = len;
                n_map++;
                return 1;
            end
        return 0;
    endfunction

    // advance the tables by one request and return the reply it causes
    function automatic reply_t predict_reply(bit [3:0] op, bit [4:0] sl, u64_t cnt,
                                             u64_t va, u64_t off);
        reply_t r;
        int     s;
        bit     pass, live, act, res;
        u64_t   where;
        s = sl;
        pass = 0;
        live = 1;
        if (op == OP_CREATE) begin
            s = NBUF;
            if (cnt != 0 && cnt <= MAX_BUF_BYTES)
                for (int i = 0; i < NBUF; i++)
                    if (!b_act[i]) begin
                        s = i;
                        break;
                    end
            if (s < NBUF) begin
                free_buffer(s);
                b_act[s] = 1;
                b_hnd[s] = handle_ctr++;
                if (b_hnd[s] == 0) b_hnd[s] = handle_ctr++;
                b_len[s] = ((cnt + PG - 1) / PG) * PG;
                n_buf++;
                pass = 1;
            end else begin
                s = 0;
                live = 0;
            end
        end else begin
            act = b_act[s];
            res = b_res[s];
            case (op)
                OP_RESERVE:   if (act && !res) begin b_res[s] = 1; pass = 1; end
                OP_UNRESERVE: if (act) begin b_res[s] = 0; pass = 1; end
                OP_PLACE_AP:
                    if (act && res) begin
                        if (b_plc[s]) pass = 1;
                        else if (aperture_fit(s, where)) begin
                            b_addr[s] = where; b_plc[s] = 1; pass = 1;
                        end
                    end
                OP_PLACE_SYS:
                    if (act && res) begin
                        if (!b_plc[s]) pass = 1;
                        else if (b_pins[s] == 0) begin
                            b_plc[s] = 0; b_addr[s] = AMASK; pass = 1;
                        end
                    end
                OP_PIN:
                    if (act && res && b_plc[s] && b_pins[s] != 32'hFFFF_FFFF) begin
                        b_pins[s]++; pass = 1;
                    end
                OP_UNPIN:
                    if (act && res && b_pins[s] != 0) begin
                        b_pins[s]--; pass = 1;
                    end
                OP_MAP: pass = map_insert(s, va, off, cnt);
                OP_UNMAP:
                    if (act && res)
                        for (int i = 0; i < NMAP; i++)
                            if (m_act[i] && m_own[i] == s && m_va[i] == va) begin
                                m_act[i] = 0; n_map--; pass = 1;
                                break;
                            end
                OP_DESTROY:
                    if (act) begin
                        for (int i = 0; i < NMAP; i++)
                            if (m_act[i] && m_own[i] == s) begin
                                m_act[i] = 0; n_map--;
                            end
                        free_buffer(s);
                        n_buf--;
                        pass = 1;
                    end
                default: ;
            endcase
        end
        r.ok = pass;
        r.rslot = s[4:0];
        if (live && b_act[s]) begin
            r.hnd = b_hnd[s];
            r.addr = b_plc[s] ? b_addr[s][47:0] : AMASK[47:0];
            r.nbytes = b_len[s][25:0];
            r.inap = b_plc[s];
        end else begin
            r.hnd = 0; r.addr = AMASK[47:0]; r.nbytes = 0; r.inap = 0;
        end
        r.blive = n_buf[5:0];
        r.mlive = n_map[6:0];
        if (pass && op == OP_MAP) maps_ok++;
        if (pass && op == OP_PLACE_AP) places_ok++;
        return r;
    endfunction

    task automatic report_mismatch(string what, u64_t got, u64_t want);
        errors++;
        $display("MISMATCH reply %0d %s: got %0h expected %0h", replies_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Reply checker and watchdog, sampled mid-cycle away from the edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        reply_t w;
        if (rst_n && done) begin
            if (reply_q.size() == 0) begin
                report_mismatch("reply word with none pending", 64'd1, 64'd0);
            end else begin
                w = reply_q.pop_front();
                if (ok !== w.ok)                    report_mismatch("ok", ok, w.ok);
                if (result_slot !== w.rslot)        report_mismatch("result_slot", result_slot, w.rslot);
                if (handle !== w.hnd)               report_mismatch("handle", handle, w.hnd);
                if (placed_addr !== w.addr)         report_mismatch("placed_addr", placed_addr, w.addr);
                if (buffer_bytes !== w.nbytes)      report_mismatch("buffer_bytes", buffer_bytes, w.nbytes);
                if (in_aperture !== w.inap)         report_mismatch("in_aperture", in_aperture, w.inap);
                if (buffers_live !== w.blive)       report_mismatch("buffers_live", buffers_live, w.blive);
                if (mappings_live !== w.mlive)      report_mismatch("mappings_live", mappings_live, w.mlive);
            end
            replies_seen++;
        end
        // count cycles without progress on either side
        if (done || accept_seen) idle_cycles = 0;
        else idle_cycles++;
        accept_seen = 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver helpers; each is entered and left right at a rising edge
    // ------------------------------------------------------------------
    task automatic send_word(bit [3:0] op, bit [4:0] sl, bit [27:0] cnt, bit [47:0] va,
                             bit [24:0] off);
        reply_t r;
        start <= 1'b1;
        opcode <= op; slot <= sl; byte_count <= cnt; virt_addr <= va; buffer_offset <= off;
        // hold the word until busy is seen low ahead of an edge
        forever begin
            @(negedge clk);
            if (!busy) break;
        end
        @(posedge clk);
        accept_seen = 1;
        words_sent++;
        r = predict_reply(op, sl, 64'(cnt), 64'(va), 64'(off));
        reply_q.push_back(r);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
    endtask

    // drop start and wait until every reply is in, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one write per call, with the enable dropped after it
    task automatic write_reg(bit [1:0] idx, bit [47:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_AP_BASE:  ap_base  = 64'(val);
            CFG_AP_BYTES: ap_len   = 64'(val) & ((64'd1 << 41) - 1);
            CFG_VA_BASE:  win_base = 64'(val);
            default:      win_len  = 64'(val) & ((64'd1 << 41) - 1);
        endcase
    endtask

    task automatic set_windows(bit [47:0] ab, bit [47:0] al, bit [47:0] wb, bit [47:0] wl);
        drain();
        write_reg(CFG_AP_BASE, ab);
        write_reg(CFG_AP_BYTES, al);
        write_reg(CFG_VA_BASE, wb);
        write_reg(CFG_VA_BYTES, wl);
    endtask

    function automatic int pick_live_slot();
        int cand[$];
        for (int i = 0; i < NBUF; i++) if (b_act[i]) cand.push_back(i);
        if (cand.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, NBUF - 1);
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        bit [47:0] wb;
        wb = win_base[47:0];
        send_word(OP_CREATE, 0, 0, 0, 0);                     // zero size
        send_word(OP_CREATE, 0, 28'hFFF_FFFF, 0, 0);          // oversized
        send_word(OP_CREATE, 0, 28'(MAX_BUF_BYTES + 1), 0, 0);
        send_word(OP_CREATE, 7, 28'(MAX_BUF_BYTES), 0, 0);    // largest legal
        send_word(OP_CREATE, 0, 1, 0, 0);                     // rounds up to a page
        send_word(OP_PLACE_AP, 1, 0, 0, 0);                   // not reserved yet
        send_word(OP_RESERVE, 1, 0, 0, 0);
        send_word(OP_RESERVE, 1, 0, 0, 0);                    // already reserved
        send_word(OP_PLACE_SYS, 1, 0, 0, 0);                  // already in system
        send_word(OP_PLACE_AP, 1, 0, 0, 0);
        send_word(OP_PLACE_AP, 1, 0, 0, 0);                   // already placed
        send_word(OP_PIN, 1, 0, 0, 0);
        send_word(OP_PLACE_SYS, 1, 0, 0, 0);                  // pinned, refused
        send_word(OP_MAP, 1, 4096, wb + 48'd1, 0);            // misaligned va
        send_word(OP_MAP, 1, 0, wb, 0);                       // zero length
        send_word(OP_MAP, 1, 8192, wb, 0);                    // past buffer end
        send_word(OP_MAP, 1, 4096, wb, 0);
        send_word(OP_MAP, 1, 4096, wb, 0);                    // overlap
        send_word(OP_UNMAP, 1, 0, wb + 48'd4096, 0);          // no such mapping
        send_word(OP_UNPIN, 1, 0, 0, 0);
        send_word(OP_UNPIN, 1, 0, 0, 0);                      // count already zero
        send_word(4'd15, 1, 0, 0, 0);                         // unknown opcode
        send_word(4'd10, 31, 0, 0, 0);
        send_word(OP_DESTROY, 1, 0, 0, 0);                    // drops the mapping too
        send_word(OP_DESTROY, 1, 0, 0, 0);
        // whole largest buffer mapped at offset zero
        send_word(OP_RESERVE, 0, 0, 0, 0);
        send_word(OP_PLACE_AP, 0, 0, 0, 0);
        send_word(OP_MAP, 0, 28'(MAX_BUF_BYTES), wb, 0);
        send_word(OP_DESTROY, 0, 0, 0, 0);
    endtask

    // fill the mapping table from one buffer until it refuses a map
    task automatic test_mapping_table_full();
        int s;
        send_word(OP_CREATE, 0, 28'(1 << 20), 0, 0);
        s = reply_q[$].rslot;
        send_word(OP_RESERVE, 5'(s), 0, 0, 0);
        send_word(OP_PLACE_AP, 5'(s), 0, 0, 0);
        for (int i = 0; i <= NMAP; i++) begin
            maybe_gap();
            send_word(OP_MAP, 5'(s), 4096, 48'(win_base + 64'(i) * PG * 2), 0);
        end
        send_word(OP_UNMAP, 5'(s), 0, win_base[47:0], 0);
        send_word(OP_DESTROY, 5'(s), 0, 0, 0);
    endtask

    task automatic random_word();
        bit [3:0]  op;
        int        s, pick;
        bit [27:0] cnt;
        bit [47:0] va;
        bit [24:0] off;
        int        hits[$];
        s = pick_live_slot();
        pick = $urandom_range(0, 99);
        cnt = 0; va = 0; off = 0;
        if (pick < 10)      op = OP_CREATE;
        else if (pick < 22) op = OP_RESERVE;
        else if (pick < 27) op = OP_UNRESERVE;
        else if (pick < 40) op = OP_PLACE_AP;
        else if (pick < 45) op = OP_PLACE_SYS;
        else if (pick < 52) op = OP_PIN;
        else if (pick < 57) op = OP_UNPIN;
        else if (pick < 77) op = OP_MAP;
        else if (pick < 86) op = OP_UNMAP;
        else if (pick < 91) op = OP_DESTROY;
        else if (pick < 93) op = 4'($urandom_range(10, 15));
        else                op = 4'($urandom_range(0, 15));
        if (pick >= 93) begin
            // noise: every field fully random
            cnt = 28'($urandom); va = 48'({$urandom, $urandom}); off = 25'($urandom);
        end else if (op == OP_CREATE) begin
            case ($urandom_range(0, 9))
                0:       cnt = 28'($urandom);
                1:       cnt = 28'(MAX_BUF_BYTES - $urandom_range(0, 1));
                2:       cnt = 28'($urandom_range(0, 1 << 22));
                default: cnt = 28'($urandom_range(1, 1 << 16));
            endcase
        end else if (op == OP_MAP) begin
            if ($urandom_range(0, 7) != 0) begin
                cnt = 28'(PG * $urandom_range(1, 3));
                va = 48'(win_base + PG * $urandom_range(0, 255));
                off = (b_len[s] >= PG) ?
                      25'(PG * $urandom_range(0, 32'(b_len[s] / PG - 1))) : 25'd0;
            end else begin
                cnt = 28'($urandom); va = 48'(win_base + $urandom_range(0, 1 << 20));
                off = 25'($urandom);
            end
        end else if (op == OP_UNMAP) begin
            for (int i = 0; i < NMAP; i++) if (m_act[i] && m_own[i] == s) hits.push_back(i);
            if (hits.size() != 0 && $urandom_range(0, 3) != 0)
                va = 48'(m_va[hits[$urandom_range(0, hits.size() - 1)]]);
            else
                va = 48'(win_base + PG * $urandom_range(0, 255));
        end
        send_word(op, 5'(s), cnt, va, off);
    endtask

    task automatic test_random_phase(int n);
        for (int i = 0; i < n; i++) begin
            maybe_gap();
            random_word();
        end
    endtask

    // sender holds off until the block has answered everything
    task automatic test_drain_pause();
        test_random_phase(20);
        drain();
        test_random_phase(20);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        opcode = '0; slot = '0; byte_count = '0; virt_addr = '0; buffer_offset = '0;
        errors = 0; replies_seen = 0; words_sent = 0; maps_ok = 0; places_ok = 0;
        idle_cycles = 0; accept_seen = 0; no_gaps = 0;
        reset_tables();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_mapping_table_full();
        test_drain_pause();
        test_random_phase(400);

        // tight aperture and window at address zero: frequent first-fit refusals
        set_windows(48'h0, 48'h10_0000, 48'h0, 48'h10_0000);
        test_random_phase(350);

        // aperture ending past the top of the address space; upper bits masked off
        set_windows(48'hFFFF_FFF0_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FF00_0000,
                    48'h100_0000_0000);
        test_random_phase(300);

        // empty aperture and window
        set_windows(48'h0, 48'h0, 48'hFFFF_FFFF_F000, 48'h0);
        test_random_phase(150);

        // widest aperture at a random page-aligned base
        set_windows({16'($urandom_range(0, 16'h7FFF)), $urandom} & 48'hFFFF_FFFF_F000,
                    48'h100_0000_0000, {8'h00, 8'($urandom_range(0, 255)), 32'h0},
                    48'h100_0000_0000);
        test_random_phase(350);

        // back to the reset values, full rate to the end
        set_windows(48'h1_0000_0000, 48'h1000_0000, 48'h10_0000_0000, 48'h100_0000_0000);
        no_gaps = 1;
        test_random_phase(300);

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d request words and %0d replies over six window settings",
                 words_sent, replies_seen);
        $display("successful maps %0d, aperture placements %0d, mismatches %0d",
                 maps_ok, places_ok, errors);
        if (errors == 0 && reply_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
